>>> hdl/cflc_pkg.sv
// Package for the checksum frame link controller: widths, command codes, defaults.
// No dependencies.
package cflc_pkg;
   localparam int FrameBytes   = 9;
   localparam int RingDepthDef = 16;
   localparam int QueueDef     = 4;
   localparam int PosW         = 4;
   localparam logic [7:0] IdleResetVal  = 8'd10;
   localparam logic [7:0] ReplyResetVal = 8'd50;

   typedef enum logic [2:0] {
      CMD_RX_BYTE   = 3'd0,
      CMD_TICK      = 3'd1,
      CMD_TX_DONE   = 3'd2,
      CMD_LOAD      = 3'd3,
      CMD_ACK       = 3'd4,
      CMD_READ      = 3'd5,
      CMD_RSVD6     = 3'd6,
      CMD_RSVD7     = 3'd7
   } cmd_type;

   localparam logic CSR_IDLE  = 1'b0;
   localparam logic CSR_REPLY = 1'b1;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] data;
      logic [2:0] line_status;
      logic [3:0] byte_index;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_data;
      logic       tx_drive;
      logic       frame_ready;
      logic       frame_error;
      logic       awaiting_response;
      logic [7:0] read_data;
      logic [2:0] sticky_status;
      logic       rx_overflow;
      logic       queue_full;
   } rsp_type;
endpackage

>>> hdl/cflc_if.sv
// Valid/ready channel interface carrying a packed payload.
// Depends on cflc_pkg for payload types.
interface cflc_req_if (input logic clock);
   logic               valid;
   logic               ready;
   cflc_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface cflc_rsp_if (input logic clock);
   logic               valid;
   logic               ready;
   cflc_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/cflc_front.sv
// Front part: accepts items into a short queue.
// Depends on cflc_pkg.
module cflc_front #(
   parameter int Depth = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  cflc_pkg::req_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output cflc_pkg::req_type out_item
);
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   cflc_pkg::req_type mem_ff [Depth];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready  = (cnt_ff < (AW+1)'(Depth));
   assign out_valid = (cnt_ff != '0);
   assign out_item  = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wr_in = wr_ff; rd_in = rd_ff; cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == AW'(Depth-1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == AW'(Depth-1)) ? '0 : rd_ff + 1'b1;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= in_item;
   end

`ifndef SYNTHESIS
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(Depth)) else $error("queue overfilled");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != '0) else $error("pop on empty");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("count slip");
`endif
endmodule

>>> hdl/cflc_back.sv
// Back part: executes commands, sends queued frames, pops and checks received frames.
// Depends on cflc_pkg.
module cflc_back #(
   parameter int RingDepth   = cflc_pkg::RingDepthDef,
   parameter int QueueFrames = cflc_pkg::QueueDef
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        idle_ticks,
   input  logic [7:0]        reply_ticks,
   input  logic              in_valid,
   output logic              in_ready,
   input  cflc_pkg::req_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output cflc_pkg::rsp_type out_item
);
   localparam int FB  = cflc_pkg::FrameBytes;
   localparam int RA  = $clog2(RingDepth);
   localparam int QA  = $clog2(QueueFrames);
   localparam int QM  = QueueFrames * FB;
   localparam int QMA = $clog2(QM);
   localparam int PW  = cflc_pkg::PosW;

   typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_SEND, ST_OUT} state_type;
   state_type state_ff;

   logic [7:0] ring_ff [RingDepth];
   logic [7:0] oq_ff [QM];
   logic [7:0] held_ff [FB];
   logic [7:0] send_ff [FB];
   logic [RA:0] rh_ff, rt_ff;
   logic [QA:0] qh_ff, qt_ff;
   logic [PW-1:0] lpos_ff, spos_ff, cpos_ff;
   logic txing_ff, wait_ff, ready_ff, error_ff, ovf_ff;
   logic [7:0] idle_ff, reply_ff, sum_ff, oq_rd_ff;
   logic [2:0] stat_ff;
   logic cfirst_ff;
   logic rsp_valid_ff;
   cflc_pkg::rsp_type rsp_ff;
   cflc_pkg::cmd_type cmd;

   logic [RA:0] rcount;
   logic [QA:0] qcount;
   assign rcount = rt_ff - rh_ff;
   assign qcount = qt_ff - qh_ff;
   assign cmd = cflc_pkg::cmd_type'(in_item.command);
   assign in_ready  = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign out_valid = rsp_valid_ff;
   assign out_item  = rsp_ff;

   logic [QMA-1:0] qbase;
   logic [QMA-1:0] oq_addr;
   assign qbase   = QMA'(qh_ff[QA-1:0]) * QMA'(FB);
   assign oq_addr = qbase + QMA'(cpos_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; rsp_valid_ff <= 1'b0; rsp_ff <= '0;
         rh_ff <= '0; rt_ff <= '0; qh_ff <= '0; qt_ff <= '0;
         lpos_ff <= '0; spos_ff <= '0; cpos_ff <= '0; cfirst_ff <= 1'b0;
         txing_ff <= 1'b0; wait_ff <= 1'b0; ready_ff <= 1'b0;
         error_ff <= 1'b0; ovf_ff <= 1'b0;
         idle_ff <= '0; reply_ff <= '0; stat_ff <= '0; sum_ff <= '0;
      end else begin
         // result taken: clear it so the next item starts from zero fields
         if (out_valid && out_ready) begin
            rsp_valid_ff <= 1'b0;
            rsp_ff <= '0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (in_valid && in_ready) begin
                  unique case (cmd)
                     cflc_pkg::CMD_RX_BYTE: begin
                        idle_ff <= idle_ticks;
                        stat_ff <= stat_ff | in_item.line_status;
                        if (rcount >= (RA+1)'(RingDepth)) ovf_ff <= 1'b1;
                        else begin
                           ring_ff[rt_ff[RA-1:0]] <= in_item.data;
                           rt_ff <= rt_ff + 1'b1;
                        end
                     end
                     cflc_pkg::CMD_TICK: begin
                        if (wait_ff) begin
                           if (reply_ff > 8'd1) reply_ff <= reply_ff - 1'b1;
                           else begin reply_ff <= '0; wait_ff <= 1'b0; end
                        end
                        if (idle_ff != '0) idle_ff <= idle_ff - 1'b1;
                        else rh_ff <= rt_ff;
                     end
                     cflc_pkg::CMD_TX_DONE: begin
                        if (txing_ff) begin
                           if (spos_ff >= PW'(FB)) begin
                              txing_ff <= 1'b0; wait_ff <= 1'b1;
                           end else begin
                              rsp_ff.tx_valid <= 1'b1;
                              rsp_ff.tx_data  <= send_ff[spos_ff];
                              spos_ff <= spos_ff + 1'b1;
                           end
                        end
                     end
                     cflc_pkg::CMD_LOAD: begin
                        if (qcount >= (QA+1)'(QueueFrames)) rsp_ff.queue_full <= 1'b1;
                        else begin
                           oq_ff[QMA'(qt_ff[QA-1:0]) * QMA'(FB) + QMA'(lpos_ff)] <=
                              in_item.data;
                           if (lpos_ff == PW'(FB-1)) begin
                              lpos_ff <= '0; qt_ff <= qt_ff + 1'b1;
                           end else lpos_ff <= lpos_ff + 1'b1;
                        end
                     end
                     cflc_pkg::CMD_ACK: begin
                        ready_ff <= 1'b0; error_ff <= 1'b0; ovf_ff <= 1'b0;
                     end
                     cflc_pkg::CMD_READ: begin
                        if (in_item.byte_index < PW'(FB))
                           rsp_ff.read_data <= held_ff[in_item.byte_index];
                     end
                     default: ;
                  endcase
                  cpos_ff <= '0;
                  state_ff <= ST_SEND;
               end
            end
            ST_SEND: begin
               // decided on first visit; then the head frame streams in through
               // the registered queue read, data arriving in the cycle after its address
               if (cpos_ff == '0 && (qcount == '0 || txing_ff || wait_ff)) begin
                  cfirst_ff <= 1'b1; state_ff <= ST_CHECK;
               end else begin
                  if (cpos_ff != '0) send_ff[cpos_ff - 1'b1] <= oq_rd_ff;
                  if (cpos_ff == PW'(1)) begin
                     rsp_ff.tx_valid <= 1'b1;
                     rsp_ff.tx_data  <= oq_rd_ff;
                     txing_ff <= 1'b1; reply_ff <= reply_ticks; spos_ff <= PW'(1);
                  end
                  if (cpos_ff < PW'(FB)) cpos_ff <= cpos_ff + 1'b1;
                  else begin
                     qh_ff <= qh_ff + 1'b1;
                     cfirst_ff <= 1'b1; state_ff <= ST_CHECK;
                  end
               end
            end
            ST_CHECK: begin
               if (cfirst_ff) begin
                  cfirst_ff <= 1'b0; cpos_ff <= '0; sum_ff <= '0;
                  if (ready_ff || rcount < (RA+1)'(FB)) state_ff <= ST_OUT;
               end else if (cpos_ff < PW'(FB)) begin
                  held_ff[cpos_ff] <= ring_ff[rh_ff[RA-1:0]];
                  if (cpos_ff != PW'(FB-1)) sum_ff <= sum_ff + ring_ff[rh_ff[RA-1:0]];
                  else if (sum_ff == ring_ff[rh_ff[RA-1:0]]) begin
                     ready_ff <= 1'b1; wait_ff <= 1'b0;
                  end else error_ff <= 1'b1;
                  rh_ff <= rh_ff + 1'b1;
                  cpos_ff <= cpos_ff + 1'b1;
               end else state_ff <= ST_OUT;
            end
            ST_OUT: begin
               rsp_ff.tx_drive <= txing_ff;
               rsp_ff.frame_ready <= ready_ff;
               rsp_ff.frame_error <= error_ff;
               rsp_ff.awaiting_response <= wait_ff;
               rsp_ff.sticky_status <= stat_ff;
               rsp_ff.rx_overflow <= ovf_ff;
               rsp_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // outgoing queue read port, one address a cycle
   always_ff @(posedge clock) begin
      oq_rd_ff <= oq_ff[oq_addr];
   end

`ifndef SYNTHESIS
   a_ring_bound: assert property (@(posedge clock) disable iff (reset)
      rcount <= (RA+1)'(RingDepth)) else $error("ring count over depth");
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      qcount <= (QA+1)'(QueueFrames)) else $error("queue count over depth");
   a_tx_wait_excl: assert property (@(posedge clock) disable iff (reset)
      !(txing_ff && wait_ff)) else $error("transmit and wait both set");
`endif
endmodule

>>> hdl/checksum_frame_link_controller.sv
// Top level of the checksum frame link controller.
// Depends on cflc_pkg, cflc_if, cflc_front, cflc_back.
//
//  channel | direction | payload
//  req     | in        | command, data, line_status, byte_index
//  rsp     | out       | tx/link flags, read_data, status
//  csr     | in        | write enable, index, 8-bit data
//
// Each item passes the back-end steps in order: execute, decide (or decide and
// copy a starting frame), decide the check (or pop and sum a received frame),
// register the result; the front queue lies before these steps. The ring and
// queue ports move one byte at a time.
// Reset is synchronous, active high; registers return to 10 and 50.
// A stalled result holds; a two-entry queue in front keeps accepting until full.
module checksum_frame_link_controller #(
   parameter int RingDepth   = cflc_pkg::RingDepthDef,
   parameter int QueueFrames = cflc_pkg::QueueDef
) (
   input  logic       clock,
   input  logic       reset,
   cflc_req_if.sink   req,
   cflc_rsp_if.source rsp,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);
   logic [7:0] idle_ticks_ff, reply_ticks_ff;
   logic q_valid, q_ready;
   cflc_pkg::req_type q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ticks_ff  <= cflc_pkg::IdleResetVal;
         reply_ticks_ff <= cflc_pkg::ReplyResetVal;
      end else if (csr_we) begin
         if (csr_index == cflc_pkg::CSR_IDLE) idle_ticks_ff <= csr_wdata;
         else reply_ticks_ff <= csr_wdata;
      end
   end

   cflc_front #(.Depth(2)) u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_item(req.payload),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item));

   cflc_back #(.RingDepth(RingDepth), .QueueFrames(QueueFrames)) u_back (
      .clock, .reset,
      .idle_ticks(idle_ticks_ff), .reply_ticks(reply_ticks_ff),
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_item(rsp.payload));
endmodule

>>> test/checksum_frame_link_controller_tb.sv
// Self-checking testbench for checksum_frame_link_controller: random and directed items
// on the req channel, every rsp item checked against a cycle-free predictor.
// Depends on cflc_pkg, cflc_if and the RTL of the block.
module checksum_frame_link_controller_tb;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic       csr_index;
   logic [7:0] csr_wdata;

   cflc_req_if req_ch (clock);
   cflc_rsp_if rsp_ch (clock);

   checksum_frame_link_controller u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Predictor state: a mirror of the link controller
   // ---------------------------------------------------------------------
   logic [7:0] ring_mem [16];
   int         ring_rd, ring_wr;          // count modulo 32
   logic [7:0] held_bytes [9];
   logic [7:0] outq_mem [36];
   int         outq_rd, outq_wr;          // count modulo 8
   int         load_pos;
   logic [7:0] tx_bytes [9];
   int         tx_pos;
   logic       f_txing, f_wait, f_ready, f_error, f_ovf;
   logic [7:0] idle_cnt, reply_cnt;
   logic [7:0] idle_reload, reply_reload;
   logic [2:0] line_err_acc;
   bit         held_seen;                 // a frame has been popped at least once

   cflc_pkg::rsp_type expected_rsp [$];

   int   send_idle_pct;
   int   recv_idle_pct;
   int   hold_left;
   int   quiet_cycles;
   int   error_count;

   function automatic cflc_pkg::rsp_type predict_link(cflc_pkg::req_type r);
      cflc_pkg::rsp_type o;
      int         fill;
      logic [7:0] sum;
      o = '0;
      case (cflc_pkg::cmd_type'(r.command))
         cflc_pkg::CMD_RX_BYTE: begin
            idle_cnt = idle_reload;
            line_err_acc |= r.line_status;
            fill = (ring_wr + 32 - ring_rd) % 32;
            if (fill >= 16) f_ovf = 1'b1;
            else begin
               ring_mem[ring_wr % 16] = r.data;
               ring_wr = (ring_wr + 1) % 32;
            end
         end
         cflc_pkg::CMD_TICK: begin
            if (f_wait) begin
               if (reply_cnt > 0) reply_cnt--;
               if (reply_cnt == 0) f_wait = 1'b0;
            end
            if (idle_cnt > 0) idle_cnt--;
            else ring_rd = ring_wr;   // idle timeout flushes the ring
         end
         cflc_pkg::CMD_TX_DONE: begin
            if (f_txing) begin
               if (tx_pos >= 9) begin
                  f_txing = 1'b0;
                  f_wait  = 1'b1;
               end else begin
                  o.tx_valid = 1'b1;
                  o.tx_data  = tx_bytes[tx_pos];
                  tx_pos++;
               end
            end
         end
         cflc_pkg::CMD_LOAD: begin
            if ((outq_wr + 8 - outq_rd) % 8 >= 4) o.queue_full = 1'b1;
            else begin
               outq_mem[(outq_wr % 4) * 9 + load_pos] = r.data;
               load_pos++;
               if (load_pos >= 9) begin
                  load_pos = 0;
                  outq_wr = (outq_wr + 1) % 8;
               end
            end
         end
         cflc_pkg::CMD_ACK: begin
            f_ready = 1'b0;
            f_error = 1'b0;
            f_ovf   = 1'b0;
         end
         cflc_pkg::CMD_READ: begin
            if (r.byte_index < 9) o.read_data = held_bytes[r.byte_index];
         end
         default: ;
      endcase

      // next queued frame starts when the line is free
      if (outq_wr != outq_rd && !f_txing && !f_wait) begin
         for (int i = 0; i < 9; i++) tx_bytes[i] = outq_mem[(outq_rd % 4) * 9 + i];
         outq_rd   = (outq_rd + 1) % 8;
         f_txing   = 1'b1;
         reply_cnt = reply_reload;
         o.tx_valid = 1'b1;
         o.tx_data  = tx_bytes[0];
         tx_pos    = 1;
      end

      // receive check
      if (!f_ready && (ring_wr + 32 - ring_rd) % 32 >= 9) begin
         sum = 8'd0;
         for (int i = 0; i < 9; i++) begin
            held_bytes[i] = ring_mem[ring_rd % 16];
            ring_rd = (ring_rd + 1) % 32;
         end
         for (int i = 0; i < 8; i++) sum += held_bytes[i];
         held_seen = 1'b1;
         if (sum == held_bytes[8]) begin
            f_ready = 1'b1;
            f_wait  = 1'b0;
         end else f_error = 1'b1;
      end

      o.tx_drive          = f_txing;
      o.frame_ready       = f_ready;
      o.frame_error       = f_error;
      o.awaiting_response = f_wait;
      o.sticky_status     = line_err_acc;
      o.rx_overflow       = f_ovf;
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Clock, receiver side, checker, watchdog
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // rsp ready changes on the falling edge; a long hold-off is counted here
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ch.ready = 1'b0;
         hold_left--;
      end else
         rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      cflc_pkg::rsp_type e, a;
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= 20000) begin
            $display("TB_ERROR");
            $finish;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            a = rsp_ch.payload;
            if (expected_rsp.size() == 0) begin
               $display("%0t unexpected item: expected none actual %h", $time, a);
               error_count++;
            end else begin
               e = expected_rsp.pop_front();
               check_field("tx_valid", e.tx_valid, a.tx_valid);
               check_field("tx_data", e.tx_data, a.tx_data);
               check_field("tx_drive", e.tx_drive, a.tx_drive);
               check_field("frame_ready", e.frame_ready, a.frame_ready);
               check_field("frame_error", e.frame_error, a.frame_error);
               check_field("awaiting_response", e.awaiting_response, a.awaiting_response);
               check_field("read_data", e.read_data, a.read_data);
               check_field("sticky_status", e.sticky_status, a.sticky_status);
               check_field("rx_overflow", e.rx_overflow, a.rx_overflow);
               check_field("queue_full", e.queue_full, a.queue_full);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender and helpers (called at a falling edge, return at a falling edge)
   // ---------------------------------------------------------------------
   task automatic send_item(cflc_pkg::cmd_type cmd, logic [7:0] data, logic [2:0] ls,
                            logic [3:0] idx);
      cflc_pkg::req_type r;
      r = '{command: cmd, data: data, line_status: ls, byte_index: idx};
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         req_ch.payload = cflc_pkg::req_type'($urandom);
         @(negedge clock);
      end
      req_ch.valid   = 1'b1;
      req_ch.payload = r;
      do @(posedge clock); while (!req_ch.ready);
      expected_rsp.push_back(predict_link(r));
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   task automatic write_csr(logic idx, logic [7:0] value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == cflc_pkg::CSR_IDLE) idle_reload = value;
      else reply_reload = value;
   endtask

   // wait until every item is back, then cover the worst-case internal latency
   task automatic drain_link();
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // nine received bytes; a bad frame gets its checksum byte corrupted
   task automatic rx_frame(bit bad, bit extreme);
      logic [7:0] b [9];
      logic [7:0] sum;
      sum = 8'd0;
      for (int i = 0; i < 8; i++) begin
         b[i] = extreme ? 8'hFF : 8'($urandom);
         sum += b[i];
      end
      b[8] = bad ? sum ^ 8'($urandom_range(1, 255)) : sum;
      for (int i = 0; i < 9; i++)
         send_item(cflc_pkg::CMD_RX_BYTE, b[i],
                   ($urandom_range(9) == 0) ? 3'($urandom) : 3'd0, 4'($urandom));
   endtask

   task automatic random_traffic(int n_items, bit long_flush);
      int sent, pick, n;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            rx_frame($urandom_range(4) == 0, $urandom_range(19) == 0);
            sent += 9;
         end else if (pick < 32) begin
            n = $urandom_range(1, 5);
            repeat (n)
               send_item(cflc_pkg::CMD_RX_BYTE, 8'($urandom), 3'($urandom), 4'($urandom));
            sent += n;
         end else if (pick < 47) begin
            n = $urandom_range(1, (idle_reload > 37) ? 40 : idle_reload + 3);
            repeat (n)
               send_item(cflc_pkg::CMD_TICK, 8'($urandom), 3'($urandom), 4'($urandom));
            sent += n;
         end else if (pick < 62) begin
            repeat (9)
               send_item(cflc_pkg::CMD_LOAD, 8'($urandom), 3'($urandom), 4'($urandom));
            sent += 9;
         end else if (pick < 77) begin
            n = $urandom_range(1, 11);
            repeat (n)
               send_item(cflc_pkg::CMD_TX_DONE, 8'($urandom), 3'($urandom), 4'($urandom));
            sent += n;
         end else if (pick < 83) begin
            send_item(cflc_pkg::CMD_ACK, 8'($urandom), 3'($urandom), 4'($urandom));
            sent++;
         end else if (pick < 91) begin
            if (held_seen) begin
               send_item(cflc_pkg::CMD_READ, 8'($urandom), 3'($urandom), 4'($urandom));
               sent++;
            end
         end else begin
            // noise: any command, any field values
            pick = $urandom_range(7);
            if (pick == cflc_pkg::CMD_READ && !held_seen) pick = cflc_pkg::CMD_TICK;
            send_item(cflc_pkg::cmd_type'(pick), 8'($urandom), 3'($urandom), 4'($urandom));
            sent++;
         end
      end
      // long tick run so that a large idle reload still expires
      if (long_flush)
         repeat (idle_reload + 4) send_item(cflc_pkg::CMD_TICK, 8'd0, 3'd0, 4'd0);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_directed();
      write_csr(cflc_pkg::CSR_IDLE, 8'd10);
      write_csr(cflc_pkg::CSR_REPLY, 8'd50);
      send_item(cflc_pkg::CMD_TX_DONE, 8'h00, 3'd0, 4'd0);   // tx complete while idle
      send_item(cflc_pkg::CMD_RSVD6, 8'hFF, 3'd7, 4'hF);
      send_item(cflc_pkg::CMD_RSVD7, 8'h00, 3'd0, 4'd0);
      rx_frame(1'b0, 1'b1);                                  // good frame, all-ones data bytes
      send_item(cflc_pkg::CMD_RX_BYTE, 8'h00, 3'd7, 4'd0);   // partial byte, all status
      send_item(cflc_pkg::CMD_READ, 8'h00, 3'd0, 4'd0);
      send_item(cflc_pkg::CMD_READ, 8'h00, 3'd0, 4'd8);
      send_item(cflc_pkg::CMD_READ, 8'hFF, 3'd0, 4'd9);      // out of range reads zero
      send_item(cflc_pkg::CMD_READ, 8'hFF, 3'd0, 4'd15);
      send_item(cflc_pkg::CMD_ACK, 8'h00, 3'd0, 4'd0);
      send_item(cflc_pkg::CMD_TICK, 8'h00, 3'd0, 4'd0);
      drain_link();
   endtask

   task automatic test_fast_timers();
      send_idle_pct = 23;
      recv_idle_pct = 47;
      write_csr(cflc_pkg::CSR_IDLE, 8'd1);
      write_csr(cflc_pkg::CSR_REPLY, 8'd1);
      random_traffic(450, 1'b0);
      drain_link();
   endtask

   task automatic test_slow_timers_backpressure();
      send_idle_pct = 47;
      recv_idle_pct = 23;
      write_csr(cflc_pkg::CSR_IDLE, 8'd255);
      write_csr(cflc_pkg::CSR_REPLY, 8'd255);
      hold_left = 400;   // receiver stalls while the sender keeps offering items
      random_traffic(450, 1'b1);
      drain_link();
   endtask

   task automatic test_no_idle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(cflc_pkg::CSR_IDLE, 8'd7);
      write_csr(cflc_pkg::CSR_REPLY, 8'd3);
      random_traffic(450, 1'b0);
      drain_link();
   endtask

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = cflc_pkg::CSR_IDLE;
      csr_wdata      = 8'd0;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      hold_left      = 0;
      quiet_cycles   = 0;
      error_count    = 0;
      ring_rd = 0; ring_wr = 0; outq_rd = 0; outq_wr = 0;
      load_pos = 0; tx_pos = 0;
      {f_txing, f_wait, f_ready, f_error, f_ovf} = '0;
      idle_cnt = 8'd0; reply_cnt = 8'd0; line_err_acc = 3'd0;
      idle_reload = cflc_pkg::IdleResetVal; reply_reload = cflc_pkg::ReplyResetVal;
      held_seen = 1'b0;
      repeat (4) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_directed();
      test_fast_timers();
      test_slow_timers_backpressure();
      test_no_idle();

      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
